### rtl/rhwd_pkg.sv
// ============================================================================
// rhwd_pkg
// Shared types and constants for the ROI Haar wavelet decimator.
// ============================================================================
`default_nettype none

package rhwd_pkg;

    // Region limits
    localparam int unsigned MAX_REGION_PIXELS = 131072;
    localparam int unsigned MAX_FRAME_DIM     = 4096;
    localparam int unsigned HEIGHT_RATIO      = 2;
    localparam int unsigned MIN_REGION_SIDE   = 16;

    // Field widths
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned CELL_W   = 10;
    localparam int unsigned STRETCH_W = 15;

    // Pair line store: one entry per output cell column
    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned STORE_W     = 2 * PIX_W;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

    // Result queue
    localparam int unsigned RES_FIFO_DEPTH = 8;
    localparam int unsigned RES_FIFO_AW    = $clog2(RES_FIFO_DEPTH);
    localparam int unsigned RES_FIFO_CW    = $clog2(RES_FIFO_DEPTH + 1);

    // APB register map
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_REGION_LEFT   = 3'd2,
        REG_REGION_TOP    = 3'd3,
        REG_REGION_WIDTH  = 3'd4,
        REG_REGION_HEIGHT = 3'd5,
        REG_REFINE_MODE   = 3'd6
    } t_reg_idx;

    // Registers that act immediately on the pixel counters
    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [POS_W-1:0] region_left;
        logic [POS_W-1:0] region_top;
    } t_live;

    // Precomputed region check, latched at frame start
    typedef struct packed {
        logic             bad;
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
    } t_region;

    typedef struct packed {
        logic [CELL_W-1:0] cell_row;
        logic [CELL_W-1:0] cell_col;
        logic [PIX_W-1:0]  avg_of_avg;
        logic [PIX_W-1:0]  diff_of_avg;
        logic [PIX_W-1:0]  avg_of_diff;
        logic [PIX_W-1:0]  diff_of_diff;
        logic              frame_done;
        logic              region_error;
        logic [DIM_W-1:0]  used_width;
        logic [DIM_W-1:0]  used_height;
    } t_result;

endpackage

`default_nettype wire

### rtl/rhwd_if.sv
// ============================================================================
// rhwd_pix_if / rhwd_cell_if
// Valid/ready channels for the pixel input and the cell result output.
// ============================================================================
`default_nettype none

interface rhwd_pix_if;
    import rhwd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface rhwd_cell_if;
    import rhwd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic [PIX_W-1:0]  avg_of_avg;
    logic [PIX_W-1:0]  diff_of_avg;
    logic [PIX_W-1:0]  avg_of_diff;
    logic [PIX_W-1:0]  diff_of_diff;
    logic              frame_done;
    logic              region_error;
    logic [DIM_W-1:0]  used_width;
    logic [DIM_W-1:0]  used_height;

    modport source (
        output valid, cell_row, cell_col, avg_of_avg, diff_of_avg, avg_of_diff,
               diff_of_diff, frame_done, region_error, used_width, used_height,
        input  ready
    );
    modport sink (
        input  valid, cell_row, cell_col, avg_of_avg, diff_of_avg, avg_of_diff,
               diff_of_diff, frame_done, region_error, used_width, used_height,
        output ready
    );
endinterface

`default_nettype wire

### rtl/rhwd_ram.sv
// ============================================================================
// rhwd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module rhwd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/rhwd_cfg.sv
// ============================================================================
// rhwd_cfg
// APB register file and two-stage region check that follows the registers.
// ============================================================================
`default_nettype none

module rhwd_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rhwd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rhwd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rhwd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output rhwd_pkg::t_live                        o_live,
    output rhwd_pkg::t_region                      o_region
);
    import rhwd_pkg::*;

    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;
    logic [POS_W-1:0] r_region_left;
    logic [POS_W-1:0] r_region_top;
    logic [DIM_W-1:0] r_region_width;
    logic [DIM_W-1:0] r_region_height;
    logic             r_refine_mode;

    t_reg_idx         reg_idx;
    logic             wr_en;

    // Check stage 1
    logic [DIM_W:0]       wsum;
    logic [DIM_W:0]       hsum;
    logic [STRETCH_W-1:0] stretch;
    logic [STRETCH_W:0]   ssum;
    logic [STRETCH_W:0]   clip;
    logic [STRETCH_W-1:0] h_ref;
    logic                 n_bad1;
    logic                 r_bad1;
    logic [DIM_W-1:0]     r_w1;
    logic [STRETCH_W-1:0] r_h1;

    // Check stage 2
    logic [DIM_W+STRETCH_W-1:0] area;
    logic                       n_bad;
    t_region                    r_region;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= DIM_W'(640);
            r_image_height  <= DIM_W'(480);
            r_region_left   <= '0;
            r_region_top    <= '0;
            r_region_width  <= DIM_W'(16);
            r_region_height <= DIM_W'(16);
            r_refine_mode   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:   r_image_width   <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[DIM_W-1:0];
                REG_REGION_LEFT:   r_region_left   <= pwdata[POS_W-1:0];
                REG_REGION_TOP:    r_region_top    <= pwdata[POS_W-1:0];
                REG_REGION_WIDTH:  r_region_width  <= pwdata[DIM_W-1:0];
                REG_REGION_HEIGHT: r_region_height <= pwdata[DIM_W-1:0];
                REG_REFINE_MODE:   r_refine_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(r_image_height);
            REG_REGION_LEFT:   prdata = APB_DATA_W'(r_region_left);
            REG_REGION_TOP:    prdata = APB_DATA_W'(r_region_top);
            REG_REGION_WIDTH:  prdata = APB_DATA_W'(r_region_width);
            REG_REGION_HEIGHT: prdata = APB_DATA_W'(r_region_height);
            REG_REFINE_MODE:   prdata = APB_DATA_W'(r_refine_mode);
            default:           prdata = '0;
        endcase
    end

    // Stage 1: side limits, frame limits, refine stretch and rounding
    always_comb begin
        wsum    = {2'b00, r_region_left} + {1'b0, r_region_width};
        hsum    = {2'b00, r_region_top} + {1'b0, r_region_height};
        stretch = STRETCH_W'(r_region_height) * STRETCH_W'(HEIGHT_RATIO);
        ssum    = {4'd0, r_region_top} + {1'b0, stretch};
        // only meaningful on a region that passed the side checks
        clip    = {3'd0, r_image_height} - (STRETCH_W+1)'(1) - {4'd0, r_region_top};
        n_bad1  = (32'(r_region_width) < MIN_REGION_SIDE)
               || (32'(r_region_height) < MIN_REGION_SIDE)
               || (wsum > {1'b0, r_image_width})
               || (hsum > {1'b0, r_image_height})
               || (32'(r_image_width) > MAX_FRAME_DIM)
               || (32'(r_image_height) > MAX_FRAME_DIM);
        if (r_refine_mode) begin
            h_ref = (ssum < {3'd0, r_image_height}) ? stretch : clip[STRETCH_W-1:0];
        end else begin
            h_ref = STRETCH_W'(r_region_height);
        end
    end

    // Stage 2: area limit
    assign area  = (DIM_W+STRETCH_W)'(r_w1) * (DIM_W+STRETCH_W)'(r_h1);
    assign n_bad = r_bad1 || (32'(area) > MAX_REGION_PIXELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad1   <= 1'b0;
            r_w1     <= '0;
            r_h1     <= '0;
            r_region <= '0;
        end else begin
            r_bad1         <= n_bad1;
            r_w1           <= {r_region_width[DIM_W-1:2], 2'b00};
            r_h1           <= {h_ref[STRETCH_W-1:2], 2'b00};
            r_region.bad   <= n_bad;
            r_region.eff_w <= n_bad ? '0 : r_w1;
            r_region.eff_h <= n_bad ? '0 : r_h1[DIM_W-1:0];
        end
    end

    assign o_region           = r_region;
    assign o_live.image_width = r_image_width;
    assign o_live.region_left = r_region_left;
    assign o_live.region_top  = r_region_top;

endmodule

`default_nettype wire

### rtl/rhwd_ofifo.sv
// ============================================================================
// rhwd_ofifo
// Result queue between the pixel pipeline and the output channel.
// ============================================================================
`default_nettype none

module rhwd_ofifo (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  rhwd_pkg::t_result                     i_data,
    output logic [rhwd_pkg::RES_FIFO_CW-1:0]      o_count,
    rhwd_cell_if.source                           o_cell
);
    import rhwd_pkg::*;

    t_result                r_mem [RES_FIFO_DEPTH];
    logic [RES_FIFO_AW-1:0] r_wptr;
    logic [RES_FIFO_AW-1:0] r_rptr;
    logic [RES_FIFO_CW-1:0] r_count;
    logic                   pop;
    t_result                head;

    assign pop  = o_cell.valid && o_cell.ready;
    assign head = r_mem[r_rptr];

    // Storage; the upstream credit check keeps pushes off a full queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + RES_FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + RES_FIFO_AW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + RES_FIFO_CW'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - RES_FIFO_CW'(1);
            end
        end
    end

    assign o_count             = r_count;
    assign o_cell.valid        = (r_count != '0);
    assign o_cell.cell_row     = head.cell_row;
    assign o_cell.cell_col     = head.cell_col;
    assign o_cell.avg_of_avg   = head.avg_of_avg;
    assign o_cell.diff_of_avg  = head.diff_of_avg;
    assign o_cell.avg_of_diff  = head.avg_of_diff;
    assign o_cell.diff_of_diff = head.diff_of_diff;
    assign o_cell.frame_done   = head.frame_done;
    assign o_cell.region_error = head.region_error;
    assign o_cell.used_width   = head.used_width;
    assign o_cell.used_height  = head.used_height;

endmodule

`default_nettype wire

### rtl/rhwd_core.sv
// ============================================================================
// rhwd_core
// Pixel pipeline: frame counters, region test, horizontal pair and the
// read-modify-write of the pair line store that yields the vertical pair.
// ============================================================================
`default_nettype none

module rhwd_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_acc,
    input  wire logic [rhwd_pkg::PIX_W-1:0]   i_pixel,
    input  wire logic                         i_frame_start,
    input  rhwd_pkg::t_live                   i_live,
    input  rhwd_pkg::t_region                 i_region,
    output logic                              o_push,
    output rhwd_pkg::t_result                 o_result,
    output logic [1:0]                        o_pipe_cnt
);
    import rhwd_pkg::*;

    function automatic logic [PIX_W-1:0] avg8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    function automatic logic [PIX_W-1:0] absdiff8(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Frame counters
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] pos_col;
    logic [DIM_W-1:0] pos_row;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;

    // Stage 1
    logic             r_s1_vld;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_start;
    logic [DIM_W-1:0] r_s1_col;
    logic [DIM_W-1:0] r_s1_row;

    // Stage 2
    logic             r_s2_vld;
    logic [PIX_W-1:0] r_s2_pix;
    logic             r_s2_start;
    logic [DIM_W-1:0] r_s2_rx;
    logic [DIM_W-1:0] r_s2_ry;
    logic             r_s2_cge;
    logic             r_s2_rge;

    // Latched region and held pixel
    logic             r_invalid;
    logic [DIM_W-1:0] r_eff_w;
    logic [DIM_W-1:0] r_eff_h;
    logic [PIX_W-1:0] r_held;

    logic             cur_bad;
    logic [DIM_W-1:0] cur_w;
    logic [DIM_W-1:0] cur_h;
    logic             in_region;
    logic             hold_en;
    logic             pair;
    logic             ram_we;
    logic             ram_re;
    logic             err;
    logic             done;
    logic [PIX_W-1:0] ha;
    logic [PIX_W-1:0] hd;
    logic [STORE_W-1:0] rdata;

    // Stage 3
    logic              r_s3_vld;
    logic              r_s3_emit;
    logic              r_s3_err;
    logic [PIX_W-1:0]  r_s3_ha;
    logic [PIX_W-1:0]  r_s3_hd;
    logic [CELL_W-1:0] r_s3_row;
    logic [CELL_W-1:0] r_s3_col;
    logic              r_s3_done;
    logic [DIM_W-1:0]  r_s3_w;
    logic [DIM_W-1:0]  r_s3_h;
    logic [PIX_W-1:0]  sa;
    logic [PIX_W-1:0]  sd;

    // Raster position of the incoming pixel and the next one
    always_comb begin
        pos_col = i_frame_start ? '0 : r_col;
        pos_row = i_frame_start ? '0 : r_row;
        col_inc = {1'b0, pos_col} + (DIM_W+1)'(1);
        if (col_inc >= {1'b0, i_live.image_width}) begin
            n_col = '0;
            n_row = (pos_row != {DIM_W{1'b1}}) ? pos_row + DIM_W'(1) : pos_row;
        end else begin
            n_col = col_inc[DIM_W-1:0];
            n_row = pos_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_acc;
        end
        r_s1_pix   <= i_pixel;
        r_s1_start <= i_frame_start;
        r_s1_col   <= pos_col;
        r_s1_row   <= pos_row;
    end

    // Stage 2: offsets inside the region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_pix   <= r_s1_pix;
        r_s2_start <= r_s1_start && r_s1_vld;
        r_s2_rx    <= r_s1_col - {1'b0, i_live.region_left};
        r_s2_ry    <= r_s1_row - {1'b0, i_live.region_top};
        r_s2_cge   <= (r_s1_col >= {1'b0, i_live.region_left});
        r_s2_rge   <= (r_s1_row >= {1'b0, i_live.region_top});
    end

    // Region test; the frame-start pixel uses the freshly checked region
    always_comb begin
        cur_bad   = r_s2_start ? i_region.bad   : r_invalid;
        cur_w     = r_s2_start ? i_region.eff_w : r_eff_w;
        cur_h     = r_s2_start ? i_region.eff_h : r_eff_h;
        in_region = r_s2_vld && !cur_bad && r_s2_rge && (r_s2_ry < cur_h)
                 && r_s2_cge && (r_s2_rx < cur_w);
        hold_en   = in_region && !r_s2_ry[1] && (r_s2_rx[1:0] == 2'd0);
        pair      = in_region && !r_s2_ry[1] && (r_s2_rx[1:0] == 2'd1);
        ram_we    = pair && !r_s2_ry[0];
        ram_re    = pair && r_s2_ry[0];
        err       = r_s2_vld && r_s2_start && i_region.bad;
        done      = (({1'b0, r_s2_ry} + (DIM_W+1)'(3)) == {1'b0, cur_h})
                 && (({1'b0, r_s2_rx} + (DIM_W+1)'(3)) == {1'b0, cur_w});
        ha        = avg8(r_held, r_s2_pix);
        hd        = absdiff8(r_held, r_s2_pix);
    end

    // Region latch and held pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid <= 1'b0;
            r_eff_w   <= '0;
            r_eff_h   <= '0;
            r_held    <= '0;
        end else begin
            if (r_s2_start) begin
                r_invalid <= i_region.bad;
                r_eff_w   <= i_region.eff_w;
                r_eff_h   <= i_region.eff_h;
            end
            if (hold_en) begin
                r_held <= r_s2_pix;
            end
        end
    end

    // Pair line store: row 4y writes, row 4y+1 reads the same column entry.
    // The two accesses lie a full frame row apart, so they never overlap.
    rhwd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_rx[STORE_AW+1:2]),
        .i_wdata ({hd, ha}),
        .i_re    (ram_re),
        .i_raddr (r_s2_rx[STORE_AW+1:2]),
        .o_rdata (rdata)
    );

    // Stage 3 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld  <= 1'b0;
            r_s3_emit <= 1'b0;
            r_s3_err  <= 1'b0;
        end else begin
            r_s3_vld  <= r_s2_vld;
            r_s3_emit <= ram_re;
            r_s3_err  <= err;
        end
        r_s3_ha   <= ha;
        r_s3_hd   <= hd;
        r_s3_row  <= r_s2_ry[CELL_W+1:2];
        r_s3_col  <= r_s2_rx[CELL_W+1:2];
        r_s3_done <= done;
        r_s3_w    <= cur_w;
        r_s3_h    <= cur_h;
    end

    // Vertical pair and result build
    assign sa = rdata[PIX_W-1:0];
    assign sd = rdata[STORE_W-1:PIX_W];

    always_comb begin
        o_result = '0;
        if (r_s3_err) begin
            o_result.region_error = 1'b1;
        end else begin
            o_result.cell_row     = r_s3_row;
            o_result.cell_col     = r_s3_col;
            o_result.avg_of_avg   = avg8(sa, r_s3_ha);
            o_result.diff_of_avg  = absdiff8(sa, r_s3_ha);
            o_result.avg_of_diff  = avg8(sd, r_s3_hd);
            o_result.diff_of_diff = absdiff8(sd, r_s3_hd);
            o_result.frame_done   = r_s3_done;
            o_result.used_width   = r_s3_w;
            o_result.used_height  = r_s3_h;
        end
    end

    assign o_push     = r_s3_emit || r_s3_err;
    assign o_pipe_cnt = {1'b0, r_s1_vld} + {1'b0, r_s2_vld} + {1'b0, r_s3_vld};

endmodule

`default_nettype wire

### rtl/roi_haar_wavelet_decimator.sv
// ============================================================================
// roi_haar_wavelet_decimator
// Crops a region of interest out of a raster luma stream and emits one
// single-level 2D Haar cell (four bytes) per 4x4 block of the region.
// ============================================================================
//
//   port      dir   kind        payload
//   i_pix     in    valid/ready pixel[7:0], frame_start
//   o_cell    out   valid/ready cell_row, cell_col, four Haar bytes, frame_done,
//                               region_error, used_width, used_height
//   APB       in    psel/penable write, pready tied high, 5-bit byte address
//
// Throughput: one pixel per clock while i_pix.ready is high; each pixel does
// at most one store write or one store read on the single-port-per-direction
// line RAM. i_pix.ready drops only when results held in the 8-entry output
// queue plus pixels still in the three pipeline stages reach the queue depth.
// Reset: synchronous, active low; the line store needs no clearing pass.
// A register write reaches the region check via its stage 1 and 2 registers.
// ============================================================================
`default_nettype none

module roi_haar_wavelet_decimator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    rhwd_pix_if.sink                               i_pix,
    rhwd_cell_if.source                            o_cell,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rhwd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rhwd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rhwd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import rhwd_pkg::*;

    t_live                  live;
    t_region                region;
    t_result                result;
    logic                   push;
    logic                   acc;
    logic [1:0]             pipe_cnt;
    logic [RES_FIFO_CW-1:0] fifo_cnt;
    logic [RES_FIFO_CW:0]   pending;

    // Credit check: every pixel in flight may still produce one result
    assign pending     = (RES_FIFO_CW+1)'(fifo_cnt) + (RES_FIFO_CW+1)'(pipe_cnt);
    assign i_pix.ready = (pending < (RES_FIFO_CW+1)'(RES_FIFO_DEPTH));
    assign acc         = i_pix.valid && i_pix.ready;

    rhwd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_live   (live),
        .o_region (region)
    );

    rhwd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_live        (live),
        .i_region      (region),
        .o_push        (push),
        .o_result      (result),
        .o_pipe_cnt    (pipe_cnt)
    );

    rhwd_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_count (fifo_cnt),
        .o_cell  (o_cell)
    );

endmodule

`default_nettype wire

### rtl/rhwd_checker.sv
// ============================================================================
// rhwd_checker
// Port-level assertions for the decimator, bound to the top level.
// ============================================================================
`default_nettype none

module rhwd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [9:0]  i_cell_row,
    input wire logic [9:0]  i_cell_col,
    input wire logic [7:0]  i_avg_of_avg,
    input wire logic [7:0]  i_diff_of_avg,
    input wire logic [7:0]  i_avg_of_diff,
    input wire logic [7:0]  i_diff_of_diff,
    input wire logic        i_frame_done,
    input wire logic        i_region_error,
    input wire logic [12:0] i_used_width,
    input wire logic [12:0] i_used_height
);

    // Reset empties the result queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending right after reset");

    // An error transaction carries nothing but the error flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_region_error |->
            i_cell_row == 10'd0 && i_cell_col == 10'd0 && i_avg_of_avg == 8'd0 &&
            i_diff_of_avg == 8'd0 && i_avg_of_diff == 8'd0 &&
            i_diff_of_diff == 8'd0 && !i_frame_done &&
            i_used_width == 13'd0 && i_used_height == 13'd0)
        else $error("error transaction with nonzero fields");

    // Cell sizes are rounded to a multiple of four and the width is at least 16 pixels
    a_size_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_region_error |->
            i_used_width[1:0] == 2'b00 && i_used_height[1:0] == 2'b00 &&
            i_used_width >= 13'd16)
        else $error("cell transaction with bad region size");

    // Cell indices stay within the used region
    a_cell_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_region_error |->
            {1'b0, i_cell_col, 2'b00} < i_used_width &&
            {1'b0, i_cell_row, 2'b00} < i_used_height)
        else $error("cell index outside used region");

    // A stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cell_row) && $stable(i_cell_col) &&
            $stable(i_avg_of_avg) && $stable(i_region_error))
        else $error("stalled transaction changed");

endmodule

bind roi_haar_wavelet_decimator rhwd_checker u_rhwd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_cell.valid),
    .i_out_ready    (o_cell.ready),
    .i_cell_row     (o_cell.cell_row),
    .i_cell_col     (o_cell.cell_col),
    .i_avg_of_avg   (o_cell.avg_of_avg),
    .i_diff_of_avg  (o_cell.diff_of_avg),
    .i_avg_of_diff  (o_cell.avg_of_diff),
    .i_diff_of_diff (o_cell.diff_of_diff),
    .i_frame_done   (o_cell.frame_done),
    .i_region_error (o_cell.region_error),
    .i_used_width   (o_cell.used_width),
    .i_used_height  (o_cell.used_height)
);

`default_nettype wire
